// ===== rtl/otm_pkg.sv =====
// shared types, constants and register codes of the over-temperature monitor
`default_nettype none

package otm_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 12;

  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned DEG_W      = 8;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned DELAY_W    = 17;
  localparam int unsigned AGE_W      = 18;
  localparam int unsigned LEVEL_W    = 2;
  localparam int unsigned INDEX_W    = 3;
  localparam int unsigned CFG_DATA_W = 17;

  localparam int unsigned OUT_W       = 1 + DEG_W + LEVEL_W + 1 + 1;
  localparam int unsigned OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  localparam logic [PERIOD_W-1:0] PERIOD_RST    = 16'd50;
  localparam logic [GAIN_W-1:0]   GAIN_RST      = 16'd5280;
  localparam logic [DEG_W-1:0]    THRESHOLD_RST = 8'd50;
  localparam logic [COUNT_W-1:0]  COUNT_RST     = 4'd5;
  localparam logic [DELAY_W-1:0]  DELAY_RST     = 17'd10000;

  localparam logic [DEG_W-1:0] WARN_LIMIT = 8'd35;
  localparam logic [DEG_W-1:0] CRIT_LIMIT = 8'd50;
  localparam logic [DEG_W-1:0] DEG_MAX    = 8'hFF;
  localparam logic [AGE_W-1:0] AGE_MAX    = '1;

  typedef enum logic [INDEX_W-1:0] {
    REG_PERIOD    = 3'd0,
    REG_GAIN      = 3'd1,
    REG_THRESHOLD = 3'd2,
    REG_COUNT     = 3'd3,
    REG_DELAY     = 3'd4
  } reg_index_e;

  typedef enum logic [LEVEL_W-1:0] {
    LEVEL_BLANK    = 2'd0,
    LEVEL_WARNING  = 2'd1,
    LEVEL_CRITICAL = 2'd2
  } level_e;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [GAIN_W-1:0]   gain;
    logic [DEG_W-1:0]    threshold;
    logic [COUNT_W-1:0]  count_needed;
    logic [DELAY_W-1:0]  delay;
  } cfg_t;

  typedef struct packed {
    logic             sampled;
    logic [DEG_W-1:0] temperature;
    level_e           level;
    logic             alert;
    logic             critical;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/otm_cfg.sv =====
// configuration register file of the over-temperature monitor
`default_nettype none

module otm_cfg (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_wr_en_i,
  input  wire logic [otm_pkg::INDEX_W-1:0]       cfg_index_i,
  input  wire logic [otm_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output otm_pkg::cfg_t                          cfg_o
);
  import otm_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr_en_i) begin
      unique case (reg_index_e'(cfg_index_i))
        REG_PERIOD:    cfg_d.period       = cfg_data_i[PERIOD_W-1:0];
        REG_GAIN:      cfg_d.gain         = cfg_data_i[GAIN_W-1:0];
        REG_THRESHOLD: cfg_d.threshold    = cfg_data_i[DEG_W-1:0];
        REG_COUNT:     cfg_d.count_needed = cfg_data_i[COUNT_W-1:0];
        REG_DELAY:     cfg_d.delay        = cfg_data_i[DELAY_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period       <= PERIOD_RST;
      cfg_q.gain         <= GAIN_RST;
      cfg_q.threshold    <= THRESHOLD_RST;
      cfg_q.count_needed <= COUNT_RST;
      cfg_q.delay        <= DELAY_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/otm_convert.sv =====
// raw sample to whole degrees and message level
`default_nettype none

module otm_convert #(
  parameter int unsigned SAMPLE_BITS = otm_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic [SAMPLE_BITS-1:0]       sample_i,
  input  wire logic [otm_pkg::GAIN_W-1:0]   gain_i,
  output logic [otm_pkg::DEG_W-1:0]         deg_o,
  output otm_pkg::level_e                   level_o
);
  import otm_pkg::*;

  localparam int unsigned PROD_W = SAMPLE_BITS + GAIN_W;

  logic [PROD_W-1:0]      prod;
  logic [SAMPLE_BITS-1:0] deg_full;

  assign prod     = PROD_W'(sample_i) * PROD_W'(gain_i);
  assign deg_full = prod[PROD_W-1:GAIN_W];

  // saturate to the 8-bit degree range
  assign deg_o = (deg_full > SAMPLE_BITS'(DEG_MAX)) ? DEG_MAX : deg_full[DEG_W-1:0];

  always_comb begin
    if (deg_o >= CRIT_LIMIT) begin
      level_o = LEVEL_CRITICAL;
    end else if (deg_o >= WARN_LIMIT) begin
      level_o = LEVEL_WARNING;
    end else begin
      level_o = LEVEL_BLANK;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/otm_track.sv =====
// read scheduling, hot-run persistence, alert and critical state
`default_nettype none

module otm_track (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          step_i,
  input  wire otm_pkg::cfg_t                 cfg_i,
  input  wire logic [otm_pkg::DEG_W-1:0]     deg_i,
  input  wire otm_pkg::level_e               level_i,
  output otm_pkg::result_t                   result_o
);
  import otm_pkg::*;

  logic [PERIOD_W-1:0] ticks_q, ticks_d;
  logic [COUNT_W-1:0]  count_q, count_d;
  logic                alert_q, alert_d;
  logic                crit_q, crit_d;
  logic [AGE_W-1:0]    age_q, age_d;
  logic [DEG_W-1:0]    temp_q, temp_d;
  level_e              level_q, level_d;

  logic             read;
  logic             hot;
  logic [AGE_W-1:0] age_inc;

  assign read    = (ticks_q == '0);
  assign hot     = (deg_i >= cfg_i.threshold);
  assign age_inc = (alert_q && (age_q != AGE_MAX)) ? age_q + 1'b1 : age_q;

  always_comb begin
    ticks_d = ticks_q - 1'b1;
    count_d = count_q;
    alert_d = alert_q;
    crit_d  = crit_q;
    age_d   = age_inc;
    temp_d  = temp_q;
    level_d = level_q;
    if (read) begin
      ticks_d = cfg_i.period;
      temp_d  = deg_i;
      level_d = level_i;
      if (hot) begin
        if (count_q < cfg_i.count_needed) begin
          count_d = count_q + 1'b1;
        end
        if ((count_d >= cfg_i.count_needed) && !alert_q) begin
          alert_d = 1'b1;
          age_d   = '0;
        end
        if (alert_d && (age_d > AGE_W'(cfg_i.delay))) begin
          crit_d = 1'b1;
        end
      end else begin
        count_d = '0;
        alert_d = 1'b0;
        crit_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= PERIOD_RST;
      count_q <= '0;
      alert_q <= 1'b0;
      crit_q  <= 1'b0;
      age_q   <= '0;
      temp_q  <= '0;
      level_q <= LEVEL_BLANK;
    end else if (step_i) begin
      ticks_q <= ticks_d;
      count_q <= count_d;
      alert_q <= alert_d;
      crit_q  <= crit_d;
      age_q   <= age_d;
      temp_q  <= temp_d;
      level_q <= level_d;
    end
  end

  assign result_o.sampled     = read;
  assign result_o.temperature = temp_d;
  assign result_o.level       = level_d;
  assign result_o.alert       = alert_d;
  assign result_o.critical    = crit_d;

endmodule

`default_nettype wire

// ===== rtl/over_temperature_monitor_unit.sv =====
// over-temperature monitor: one tick per request, result per tick
// throughput: one tick per cycle while the master side takes results;
// the sample register holds the tick and feeds one multiply, compares and
// state update that close into the result register
// reset: read counter loads 50, hot count, alert, critical, age and last
// reading clear, configuration registers take their default values
`default_nettype none

module over_temperature_monitor_unit #(
  parameter int unsigned SAMPLE_BITS = otm_pkg::SAMPLE_BITS_DEF,
  localparam int unsigned IN_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_wr_en_i,
  input  wire logic [otm_pkg::INDEX_W-1:0]       cfg_index_i,
  input  wire logic [otm_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // adc_sample
  input  wire logic [IN_TDATA_W-1:0]             s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // sampled, temperature_deg, message_level, alert_flag, critical_flag
  output logic [otm_pkg::OUT_TDATA_W-1:0]        m_axis_tdata
);
  import otm_pkg::*;

  localparam int unsigned PAD_W = OUT_TDATA_W - OUT_W;

  cfg_t                   cfg;
  logic                   in_valid_q;
  logic [SAMPLE_BITS-1:0] in_sample_q;
  logic                   out_valid_q;
  result_t                out_result_q;
  logic                   advance;
  logic                   step;
  logic [DEG_W-1:0]       deg;
  level_e                 level;
  result_t                result;

  otm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_wr_en_i (cfg_wr_en_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  otm_convert #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_convert (
    .sample_i (in_sample_q),
    .gain_i   (cfg.gain),
    .deg_o    (deg),
    .level_o  (level)
  );

  otm_track u_track (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .cfg_i    (cfg),
    .deg_i    (deg),
    .level_i  (level),
    .result_o (result)
  );

  assign advance       = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_sample_q <= s_axis_tdata[SAMPLE_BITS-1:0];
    end
    if (step) begin
      out_result_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {PAD_W'(0), out_result_q.critical, out_result_q.alert,
                          out_result_q.level, out_result_q.temperature,
                          out_result_q.sampled};

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_result_q.critical |-> out_result_q.alert)
    else $error("critical result without alert");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready && in_valid_q)
    else $error("input stalled without a blocked result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> out_result_q.level != 2'd3)
    else $error("undefined message level");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_over_temperature_monitor_unit.sv =====
// self-checking testbench of the over-temperature monitor with a cycle-true tick predictor
`default_nettype none

module tb_over_temperature_monitor_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import otm_pkg::*;

  localparam int unsigned SAMPLE_W = SAMPLE_BITS_DEF;
  localparam int unsigned IN_W     = ((SAMPLE_W + 7) / 8) * 8;
  localparam int unsigned CALM_LO  = 300;
  localparam int unsigned CALM_HI  = 420;
  localparam int unsigned HOLD_AT  = 480;
  localparam int unsigned HOLD_LEN = 400;
  localparam int unsigned LONG_RUN = 24;
  localparam logic [INDEX_W-1:0] REG_SPARE_FIRST = INDEX_W'(REG_DELAY) + 1'b1;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_wr_en_i   = 1'b0;
  logic [INDEX_W-1:0]     cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_W-1:0]        s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  over_temperature_monitor_unit #(
    .SAMPLE_BITS(SAMPLE_W)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_wr_en_i  (cfg_wr_en_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // predictor copy of registers and state
  cfg_t                regs;
  logic [PERIOD_W-1:0] countdown;
  logic [COUNT_W-1:0]  hot_run;
  logic                alert_on;
  logic                crit_on;
  logic [AGE_W-1:0]    age;
  logic [DEG_W-1:0]    temp_held;
  level_e              level_held;

  logic [SAMPLE_W-1:0] adc_ticks[$];
  result_t             readings_due[$];
  int unsigned         mismatches = 0;
  int unsigned         rx_count;
  int unsigned         hold_left;
  logic                held_once;
  logic                calm;

  assign calm = (rx_count >= CALM_LO) && (rx_count < CALM_HI);

  function automatic result_t next_reading(input logic [SAMPLE_W-1:0] raw);
    logic [SAMPLE_W+GAIN_W-1:0] product;
    logic [SAMPLE_W-1:0]        whole;
    logic [DEG_W-1:0]           deg;
    result_t                    res;
    if (alert_on && age != AGE_MAX) age = age + 1'b1;
    res.sampled = 1'b0;
    if (countdown == '0) begin
      countdown = regs.period;
      res.sampled = 1'b1;
      product = raw * regs.gain;
      whole = product[SAMPLE_W+GAIN_W-1:GAIN_W];
      deg = (whole > SAMPLE_W'(DEG_MAX)) ? DEG_MAX : whole[DEG_W-1:0];
      temp_held = deg;
      if (deg >= CRIT_LIMIT) level_held = LEVEL_CRITICAL;
      else if (deg >= WARN_LIMIT) level_held = LEVEL_WARNING;
      else level_held = LEVEL_BLANK;
      if (deg >= regs.threshold) begin
        if (hot_run < regs.count_needed) hot_run = hot_run + 1'b1;
        if (hot_run >= regs.count_needed && !alert_on) begin
          alert_on = 1'b1;
          age = '0;
        end
        if (alert_on && age > AGE_W'(regs.delay)) crit_on = 1'b1;
      end else begin
        hot_run = '0;
        alert_on = 1'b0;
        crit_on = 1'b0;
      end
    end else begin
      countdown = countdown - 1'b1;
    end
    res.temperature = temp_held;
    res.level = level_held;
    res.alert = alert_on;
    res.critical = crit_on;
    return res;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (adc_ticks.size() != 0 && (calm || $urandom_range(99) >= 9)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_W'(adc_ticks.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_count <= 0;
      hold_left <= 0;
      held_once <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) rx_count <= rx_count + 1;
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (!held_once && rx_count >= HOLD_AT) begin
        m_axis_tready <= 1'b0;
        hold_left <= HOLD_LEN;
        held_once <= 1'b1;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= 9);
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        readings_due.push_back(next_reading(s_axis_tdata[SAMPLE_W-1:0]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (readings_due.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %0h", $time, m_axis_tdata);
          mismatches++;
        end else begin
          want = readings_due.pop_front();
          check_field("sampled", want.sampled, m_axis_tdata[0]);
          check_field("temperature_deg", want.temperature, m_axis_tdata[DEG_W:1]);
          check_field("message_level", want.level, m_axis_tdata[DEG_W+LEVEL_W:DEG_W+1]);
          check_field("alert_flag", want.alert, m_axis_tdata[DEG_W+LEVEL_W+1]);
          check_field("critical_flag", want.critical, m_axis_tdata[DEG_W+LEVEL_W+2]);
          check_field("padding", 0, m_axis_tdata[OUT_TDATA_W-1:OUT_W]);
        end
      end
    end
  end

  task automatic write_reg(input logic [INDEX_W-1:0] index, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= value;
    case (index)
      REG_PERIOD:    regs.period = value[PERIOD_W-1:0];
      REG_GAIN:      regs.gain = value[GAIN_W-1:0];
      REG_THRESHOLD: regs.threshold = value[DEG_W-1:0];
      REG_COUNT:     regs.count_needed = value[COUNT_W-1:0];
      REG_DELAY:     regs.delay = value[DELAY_W-1:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
  endtask

  task automatic set_config(input int unsigned period, input int unsigned gain,
                            input int unsigned threshold, input int unsigned count,
                            input int unsigned delay);
    write_reg(REG_PERIOD, CFG_DATA_W'(period));
    write_reg(REG_GAIN, CFG_DATA_W'(gain));
    write_reg(REG_THRESHOLD, CFG_DATA_W'(threshold));
    write_reg(REG_COUNT, CFG_DATA_W'(count));
    write_reg(REG_DELAY, CFG_DATA_W'(delay));
    end_writes();
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (adc_ticks.size() != 0 || s_axis_tvalid || readings_due.size() != 0);
    repeat (3) @(negedge clk_i);
  endtask

  // hot runs, cool readings and noise
  task automatic queue_random_ticks(input int unsigned n);
    int unsigned queued;
    int unsigned kind;
    int unsigned len;
    queued = 0;
    while (queued < n) begin
      kind = $urandom_range(9);
      if (kind <= 5) len = $urandom_range(4, 40);
      else len = $urandom_range(1, 5);
      repeat (len) begin
        if (kind <= 5) adc_ticks.push_back(SAMPLE_W'($urandom_range(2800, 4095)));
        else if (kind <= 7) adc_ticks.push_back(SAMPLE_W'($urandom_range(0, 150)));
        else adc_ticks.push_back(SAMPLE_W'($urandom_range(4095)));
      end
      queued += len;
    end
  endtask

  initial begin
    int unsigned gain;
    int unsigned threshold;
    regs = '{period: PERIOD_RST, gain: GAIN_RST, threshold: THRESHOLD_RST,
             count_needed: COUNT_RST, delay: DELAY_RST};
    countdown = PERIOD_RST;
    hot_run = '0;
    alert_on = 1'b0;
    crit_on = 1'b0;
    age = '0;
    temp_held = '0;
    level_held = LEVEL_BLANK;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings; run until the read counter is back at zero
    repeat (152) adc_ticks.push_back(SAMPLE_W'($urandom_range(4095)));
    wait_idle();

    // level boundaries, alert rise, critical after the shortest delay, gain overflow
    set_config(0, 65535, 50, 1, 0);
    adc_ticks = {adc_ticks, 12'd0, 12'd36, 12'd50, 12'd51, 12'hFFF, 12'hAAA, 12'h555,
                 12'd1, 12'hFFF, 12'd0};
    wait_idle();
    // zero hot count with zero gain: the first reading already raises alert
    set_config(0, 0, 0, 0, 0);
    for (int i = REG_SPARE_FIRST; i < 2 ** INDEX_W; i++) begin
      write_reg(INDEX_W'(i), CFG_DATA_W'($urandom));
    end
    end_writes();
    @(negedge clk_i);
    adc_ticks = {adc_ticks, 12'd0, 12'hFFF, 12'h800};
    wait_idle();
    set_config(1, 65535, 255, 15, 131071);
    adc_ticks = {adc_ticks, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'd0};
    wait_idle();

    repeat (5) begin
      case ($urandom_range(5))
        0: gain = 65535;
        1: gain = 0;
        default: gain = $urandom_range(2000, 30000);
      endcase
      case ($urandom_range(4))
        0: threshold = 0;
        1: threshold = 255;
        default: threshold = $urandom_range(20, 120);
      endcase
      set_config($urandom_range(0, 3) + ($urandom_range(3) == 0 ? 4 : 0), gain, threshold,
                 $urandom_range(15), $urandom_range(12));
      queue_random_ticks(90);
      wait_idle();
    end

    // longest period and delay: a new period only takes effect at the next reload
    set_config(0, 0, 255, 1, 131071);
    repeat (8) adc_ticks.push_back(SAMPLE_W'($urandom_range(4095)));
    wait_idle();
    write_reg(REG_PERIOD, CFG_DATA_W'(16'hFFFF));
    write_reg(REG_GAIN, CFG_DATA_W'(16'hFFFF));
    write_reg(REG_THRESHOLD, '0);
    end_writes();
    @(negedge clk_i);
    repeat (LONG_RUN) adc_ticks.push_back(SAMPLE_W'($urandom_range(4095)));
    wait_idle();

    repeat (8) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("PASS over_temperature_monitor_unit");
    end else begin
      $display("FAIL over_temperature_monitor_unit");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL over_temperature_monitor_unit");
    $finish;
  end

endmodule

`default_nettype wire

// ===== over_temperature_monitor_unit.f =====
rtl/otm_pkg.sv
rtl/otm_cfg.sv
rtl/otm_convert.sv
rtl/otm_track.sv
rtl/over_temperature_monitor_unit.sv
tb/sv/tb_over_temperature_monitor_unit.sv
